>>> rtl/bba_pkg.sv
// Shared types and constants for the buddy block allocator.
package bba_pkg;

    // Fixed field widths
    localparam int REQ_W = 16;
    localparam int ADR_W = 16;
    localparam int ORD_W = 5;
    localparam int HDR_W = 8;
    localparam int STS_W = 2;
    localparam int TOT_W = REQ_W + 1;
    localparam int IDX_W = 2;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_MIN_ORDER   = 2'd0;
    localparam logic [IDX_W-1:0] REG_MAX_ORDER   = 2'd1;
    localparam logic [IDX_W-1:0] REG_HEADER_SIZE = 2'd2;

    // Result status codes
    typedef enum logic [STS_W-1:0] {
        STS_GRANTED   = 2'd0,
        STS_TOO_LARGE = 2'd1,
        STS_NO_BLOCK  = 2'd2
    } status_t;

    // Classified request, passed from front to back through the queue
    typedef struct packed {
        logic             too_large;
        logic [ORD_W-1:0] order;
    } job_t;

    // Effective configuration (orders already saturated)
    typedef struct packed {
        logic [ORD_W-1:0] lo;
        logic [ORD_W-1:0] hi;
        logic [HDR_W-1:0] header;
    } cfg_t;

endpackage

>>> rtl/bba_front.sv
// Front end: takes request words, works out the block order and classifies them.
module bba_front (
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [bba_pkg::REQ_W-1:0] s_request_size,
    input  bba_pkg::cfg_t             cfg,
    input  logic                      q_ready,
    output logic                      q_push,
    output bba_pkg::job_t             q_job
);

    logic [bba_pkg::TOT_W-1:0] total;
    logic [bba_pkg::TOT_W-1:0] total_m1;
    logic [bba_pkg::ORD_W-1:0] raw_order;

    assign s_ready = q_ready;
    assign q_push  = s_valid && q_ready;

    // Ceiling log2 of request plus header: one above the top set bit of (total - 1)
    always_comb begin
        total     = bba_pkg::TOT_W'(s_request_size) + bba_pkg::TOT_W'(cfg.header);
        total_m1  = total - bba_pkg::TOT_W'(1);
        raw_order = '0;
        if (total > bba_pkg::TOT_W'(1)) begin
            for (int k = 0; k < bba_pkg::TOT_W; k++) begin
                if (total_m1[k]) begin
                    raw_order = bba_pkg::ORD_W'(k + 1);
                end
            end
        end
    end

    // Raise to the minimum order, otherwise refuse anything above the heap order
    always_comb begin
        q_job.too_large = 1'b0;
        q_job.order     = raw_order;
        priority if (raw_order < cfg.lo) begin
            q_job.order = cfg.lo;
        end else if (raw_order > cfg.hi) begin
            q_job.too_large = 1'b1;
        end
    end

endmodule

>>> rtl/bba_queue.sv
// Two-entry queue of classified requests between front and back.
module bba_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  bba_pkg::job_t push_job,
    output logic          not_full,
    input  logic          pop,
    output logic          not_empty,
    output bba_pkg::job_t head_job
);

    bba_pkg::job_t mem_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;

    assign not_full  = (count_reg != 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head_job  = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

>>> rtl/bba_back.sv
// Back end: searches the free slots, splits the chosen block and registers the result word.
module bba_back #(
    parameter int ADDR_BITS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  bba_pkg::cfg_t             cfg,
    input  logic                      store_clear,
    input  logic                      q_valid,
    input  bba_pkg::job_t             q_job,
    output logic                      q_pop,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [bba_pkg::STS_W-1:0] m_status,
    output logic [bba_pkg::ADR_W-1:0] m_address,
    output logic [bba_pkg::ORD_W-1:0] m_block_order
);

    localparam int SLOTS  = ADDR_BITS + 1;
    localparam int SLOT_W = $clog2(SLOTS);

    typedef enum logic {
        ST_SEARCH,
        ST_COMMIT
    } state_t;

    state_t                    state_reg;
    bba_pkg::job_t             job_reg;
    logic                      hit_reg;
    logic                      hit_next;
    logic [SLOT_W-1:0]         found_reg;
    logic [SLOT_W-1:0]         found_next;
    logic [SLOTS-1:0]          present_reg;
    logic [SLOTS-1:0]          present_next;
    logic [ADDR_BITS-1:0]      offset_reg [SLOTS];
    logic [SLOTS-1:0]          cand;
    logic [SLOTS-1:0]          split;
    logic [ADDR_BITS-1:0]      base;
    logic [ADDR_BITS-1:0]      addr_sum;
    logic                      out_free;
    logic                      grant;
    logic                      m_valid_reg;
    bba_pkg::status_t          m_status_reg;
    logic [bba_pkg::ADR_W-1:0] m_address_reg;
    logic [bba_pkg::ORD_W-1:0] m_order_reg;

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_address     = m_address_reg;
    assign m_block_order = m_order_reg;

    assign q_pop    = (state_reg == ST_SEARCH) && q_valid;
    assign out_free = !m_valid_reg || m_ready;

    // Smallest present slot in [order, hi] for the request at the queue head
    always_comb begin
        for (int k = 0; k < SLOTS; k++) begin
            cand[k] = present_reg[k] && (k >= int'(q_job.order)) && (k <= int'(cfg.hi));
        end
        hit_next   = |cand;
        found_next = '0;
        for (int k = SLOTS - 1; k >= 0; k--) begin
            if (cand[k]) begin
                found_next = SLOT_W'(k);
            end
        end
    end

    // Split: every level from the wanted order up to below the found one gets its upper half
    always_comb begin
        base     = offset_reg[found_reg];
        addr_sum = base + ADDR_BITS'(cfg.header);
        grant    = !job_reg.too_large && hit_reg;
        for (int k = 0; k < SLOTS; k++) begin
            split[k] = (k >= int'(job_reg.order)) && (k < int'(found_reg));
        end
        present_next = present_reg | split;
        present_next[found_reg] = 1'b0;
    end

    // Sequencer, store and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_SEARCH;
            m_valid_reg <= 1'b0;
            present_reg <= '0;
        end else begin
            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (store_clear) begin
                present_reg <= SLOTS'(1) << cfg.hi;
                for (int k = 0; k < SLOTS; k++) begin
                    offset_reg[k] <= '0;
                end
            end
            unique case (state_reg)
                ST_SEARCH: begin
                    if (q_valid) begin
                        job_reg   <= q_job;
                        hit_reg   <= hit_next;
                        found_reg <= found_next;
                        state_reg <= ST_COMMIT;
                    end
                end
                ST_COMMIT: begin
                    if (out_free) begin
                        m_valid_reg   <= 1'b1;
                        m_order_reg   <= job_reg.order;
                        m_address_reg <= '0;
                        if (job_reg.too_large) begin
                            m_status_reg <= bba_pkg::STS_TOO_LARGE;
                        end else if (!hit_reg) begin
                            m_status_reg <= bba_pkg::STS_NO_BLOCK;
                        end else begin
                            m_status_reg  <= bba_pkg::STS_GRANTED;
                            m_address_reg <= bba_pkg::ADR_W'(addr_sum);
                        end
                        if (grant) begin
                            present_reg <= present_next;
                            for (int k = 0; k < SLOTS; k++) begin
                                if (split[k]) begin
                                    offset_reg[k] <= base | (ADDR_BITS'(1) << k);
                                end
                            end
                        end
                        state_reg <= ST_SEARCH;
                    end
                end
                default: begin
                    state_reg <= ST_SEARCH;
                end
            endcase
        end
    end

endmodule

>>> rtl/buddy_block_allocator.sv
// Buddy block allocator: request words are widened by the header size, rounded up to a
// power-of-two order, clamped to the minimum order and refused above the heap order; a granted
// request takes the smallest free block of that order or larger, splits it down and returns
// its offset plus the header. The front end classifies one request word per cycle, while the
// two-entry queue has room; the back end searches the free slots for one request, then splits
// the block and registers the result once the output is free, and only then takes the next
// request. Results come out in request order through a registered output that holds a word
// while the next request is being searched. After reset and after every write to one of the
// three configuration registers the free store is rebuilt to a single free block at offset 0.
module buddy_block_allocator #(
    parameter int ADDR_BITS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [bba_pkg::IDX_W-1:0] cfg_index,
    input  logic [bba_pkg::HDR_W-1:0] cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [bba_pkg::REQ_W-1:0] s_request_size,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [bba_pkg::STS_W-1:0] m_status,
    output logic [bba_pkg::ADR_W-1:0] m_address,
    output logic [bba_pkg::ORD_W-1:0] m_block_order
);

    logic [bba_pkg::ORD_W-1:0] min_order_reg;
    logic [bba_pkg::ORD_W-1:0] max_order_reg;
    logic [bba_pkg::HDR_W-1:0] header_size_reg;
    logic                      store_clear_reg;
    logic                      store_clear_next;
    bba_pkg::cfg_t             cfg;
    logic                      q_push;
    logic                      q_not_full;
    logic                      q_pop;
    logic                      q_not_empty;
    bba_pkg::job_t             push_job;
    bba_pkg::job_t             head_job;

    // Effective orders saturate at the address width
    always_comb begin
        cfg.lo     = (int'(min_order_reg) > ADDR_BITS) ? bba_pkg::ORD_W'(ADDR_BITS)
                                                       : min_order_reg;
        cfg.hi     = (int'(max_order_reg) > ADDR_BITS) ? bba_pkg::ORD_W'(ADDR_BITS)
                                                       : max_order_reg;
        cfg.header = header_size_reg;
    end

    always_comb begin
        store_clear_next = 1'b0;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                bba_pkg::REG_MIN_ORDER,
                bba_pkg::REG_MAX_ORDER,
                bba_pkg::REG_HEADER_SIZE: store_clear_next = 1'b1;
                default:                  store_clear_next = 1'b0;
            endcase
        end
    end

    // Configuration registers; a valid write also rebuilds the free store
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_order_reg   <= bba_pkg::ORD_W'(4);
            max_order_reg   <= bba_pkg::ORD_W'(16);
            header_size_reg <= bba_pkg::HDR_W'(8);
            store_clear_reg <= 1'b1;
        end else begin
            store_clear_reg <= store_clear_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    bba_pkg::REG_MIN_ORDER:   min_order_reg   <= cfg_wdata[bba_pkg::ORD_W-1:0];
                    bba_pkg::REG_MAX_ORDER:   max_order_reg   <= cfg_wdata[bba_pkg::ORD_W-1:0];
                    bba_pkg::REG_HEADER_SIZE: header_size_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    bba_front u_front (
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_request_size (s_request_size),
        .cfg            (cfg),
        .q_ready        (q_not_full),
        .q_push         (q_push),
        .q_job          (push_job)
    );

    bba_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_job  (push_job),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_job  (head_job)
    );

    bba_back #(
        .ADDR_BITS (ADDR_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .store_clear   (store_clear_reg),
        .q_valid       (q_not_empty),
        .q_job         (head_job),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_address     (m_address),
        .m_block_order (m_block_order)
    );

endmodule

>>> rtl/bba_checker.sv
// Port-level checks on the allocator result channel, bound to the top level.
module bba_checker #(
    parameter int ADDR_BITS = 16
) (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic [bba_pkg::STS_W-1:0] m_status,
    input logic [bba_pkg::ADR_W-1:0] m_address,
    input logic [bba_pkg::ORD_W-1:0] m_block_order
);

    // A stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_address)
            && $stable(m_block_order))
        else $error("result word changed while stalled");

    // Only the three defined status codes appear
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == bba_pkg::STS_GRANTED) || (m_status == bba_pkg::STS_TOO_LARGE)
            || (m_status == bba_pkg::STS_NO_BLOCK))
        else $error("undefined status code");

    // Refused requests carry a zero address
    a_refused_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != bba_pkg::STS_GRANTED) |-> (m_address == '0))
        else $error("refused request with nonzero address");

    // A granted block never exceeds the heap address width
    a_grant_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == bba_pkg::STS_GRANTED) |-> (int'(m_block_order) <= ADDR_BITS))
        else $error("granted block order beyond address width");

endmodule

bind buddy_block_allocator bba_checker #(
    .ADDR_BITS (ADDR_BITS)
) u_bba_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_address     (m_address),
    .m_block_order (m_block_order)
);

>>> bench/tb_buddy_block_allocator.sv
// Self-checking testbench for the buddy block allocator: allocation prediction and result checks.
module tb_buddy_block_allocator;
    import bba_pkg::*;

    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;   // index past the register list
    localparam int RESET_CYCLES = 11;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int ITEM_TARGET  = 650;

    // One allocation result word
    typedef struct packed {
        status_t          status;
        logic [ADR_W-1:0] address;
        logic [ORD_W-1:0] order;
    } alloc_result_t;

    // Tracks the heap store and the allocation results still owed by the block
    class alloc_tracker;
        logic [ORD_W-1:0] min_ord;
        logic [ORD_W-1:0] max_ord;
        logic [HDR_W-1:0] hdr;
        logic [ADR_W:0]   free_present;
        logic [ADR_W-1:0] free_offset [ADR_W+1];
        alloc_result_t    expected_allocs [$];
        int               mismatches;

        function new();
            min_ord    = 5'd4;
            max_ord    = 5'd16;
            hdr        = 8'd8;
            mismatches = 0;
            rebuild_heap();
        endfunction

        function int clamp_order(logic [ORD_W-1:0] v);
            return (v > ADR_W) ? ADR_W : int'(v);
        endfunction

        // One free block covering the whole heap
        function void rebuild_heap();
            foreach (free_offset[k]) free_offset[k] = '0;
            free_present = '0;
            free_present[clamp_order(max_ord)] = 1'b1;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [HDR_W-1:0] value);
            case (idx)
                REG_MIN_ORDER:   min_ord = value[ORD_W-1:0];
                REG_MAX_ORDER:   max_ord = value[ORD_W-1:0];
                REG_HEADER_SIZE: hdr     = value;
                default:         return;
            endcase
            rebuild_heap();
        endfunction

        function int pending();
            return expected_allocs.size();
        endfunction

        // Work out the allocation for one accepted request word
        function void note_request(logic [REQ_W-1:0] size);
            logic [TOT_W-1:0] total;
            int               ord;
            int               lo;
            int               hi;
            int               found;
            logic [ADR_W-1:0] base;
            alloc_result_t    r;
            total = TOT_W'(size) + TOT_W'(hdr);
            ord   = 0;
            while (ord < 31 && (longint'(1) << ord) < total) ord++;
            lo        = clamp_order(min_ord);
            hi        = clamp_order(max_ord);
            r.status  = STS_GRANTED;
            r.address = '0;
            if (ord < lo) begin
                ord = lo;
            end else if (ord > hi) begin
                r.status = STS_TOO_LARGE;
            end
            r.order = ORD_W'(ord);
            if (r.status == STS_GRANTED) begin
                found = -1;
                for (int k = ord; k <= hi; k++)
                    if (found < 0 && free_present[k]) found = k;
                if (found < 0) begin
                    r.status = STS_NO_BLOCK;
                end else begin
                    // split down, upper half of each level stays free
                    base = free_offset[found];
                    free_present[found] = 1'b0;
                    while (found > ord) begin
                        found--;
                        free_offset[found]  = base + (ADR_W'(1) << found);
                        free_present[found] = 1'b1;
                    end
                    r.address = base + ADR_W'(hdr);
                end
            end
            expected_allocs.push_back(r);
        endfunction

        function void check_result(logic [STS_W-1:0] sts, logic [ADR_W-1:0] adr,
                                   logic [ORD_W-1:0] ord);
            alloc_result_t exp_r;
            if (expected_allocs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected word status=%0d address=%0h order=%0d",
                             sts, adr, ord);
                return;
            end
            exp_r = expected_allocs.pop_front();
            if (exp_r.status !== sts || exp_r.address !== adr || exp_r.order !== ord) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: expected status=%0d address=%0h order=%0d, got %0d %0h %0d",
                             exp_r.status, exp_r.address, exp_r.order, sts, adr, ord);
            end
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [IDX_W-1:0]    cfg_index;
    logic [HDR_W-1:0]    cfg_wdata;
    logic                s_valid;
    logic                s_ready;
    logic [REQ_W-1:0]    s_request_size;
    logic                m_valid;
    logic                m_ready;
    logic [STS_W-1:0]    m_status;
    logic [ADR_W-1:0]    m_address;
    logic [ORD_W-1:0]    m_block_order;

    alloc_tracker        tracker;
    int                  send_gap_max;
    int                  recv_gap_max;
    bit                  hold_off_req;
    int                  items_sent;
    int                  cycle_count;
    logic [ORD_W-1:0]    cur_max;
    logic [HDR_W-1:0]    cur_hdr;

    buddy_block_allocator u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_request_size (s_request_size),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_address      (m_address),
        .m_block_order  (m_block_order)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Register write: one enable cycle, then the enable is low again before the task returns
    task automatic write_cfg(logic [IDX_W-1:0] idx, logic [HDR_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        tracker.write_reg(idx, value);
        if (idx == REG_MAX_ORDER) cur_max = value[ORD_W-1:0];
        if (idx == REG_HEADER_SIZE) cur_hdr = value;
        @(posedge aclk);
    endtask

    // Offer one request word; called and returns on a clock edge
    task automatic send_request(logic [REQ_W-1:0] size);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_request_size <= size;
        do @(posedge aclk); while (!s_ready);
        tracker.note_request(size);
        items_sent++;
    endtask

    // Stop offering and wait until every owed result has come back
    task automatic drain();
        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Random request size, mostly sized to fit the current heap
    function automatic logic [REQ_W-1:0] pick_size();
        int pick;
        int t;
        int bytes;
        int hi;
        pick = $urandom_range(0, 99);
        hi   = (cur_max > ADR_W) ? ADR_W : int'(cur_max);
        if (pick < 70) begin
            t     = $urandom_range(0, hi);
            bytes = $urandom_range(0, 1 << t);
            return (bytes > cur_hdr) ? REQ_W'(bytes - cur_hdr) : '0;
        end else if (pick < 85) begin
            return REQ_W'($urandom);
        end
        return REQ_W'(16'hFFFF - $urandom_range(0, 300));
    endfunction

    // One random phase: new settings, then a burst of requests
    task automatic run_phase(bit with_hold);
        int n;
        logic [HDR_W-1:0] mn;
        logic [HDR_W-1:0] mx;
        logic [HDR_W-1:0] hd;
        case ($urandom_range(0, 5))
            0: begin mn = 8'd0;  mx = 8'd16; hd = 8'd0;   end
            1: begin mn = 8'd16; mx = 8'd16; hd = 8'd255; end
            2: begin mn = 8'($urandom); mx = 8'($urandom); hd = 8'($urandom); end
            default: begin
                mn = 8'($urandom_range(0, 6));
                mx = 8'($urandom_range(mn + 2, 16));
                hd = 8'($urandom_range(0, 255));
            end
        endcase
        write_cfg(REG_MIN_ORDER, mn);
        write_cfg(REG_MAX_ORDER, mx);
        write_cfg(REG_HEADER_SIZE, hd);
        send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 14;
        recv_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 14;
        n = $urandom_range(10, 30);
        if (with_hold) begin
            send_gap_max = 0;
            hold_off_req = 1'b1;
            n = 30;
        end
        repeat (n) send_request(pick_size());
        drain();
    endtask

    // Result side: random back-pressure, one long hold-off on request
    initial begin
        int gap;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
            end
            gap = $urandom_range(0, recv_gap_max);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            tracker.check_result(m_status, m_address, m_block_order);
        end
    end

    // Stimulus and end of run
    initial begin
        int phase;
        tracker        = new();
        send_gap_max   = 14;
        recv_gap_max   = 14;
        hold_off_req   = 1'b0;
        items_sent     = 0;
        cur_max        = 5'd16;
        cur_hdr        = 8'd8;
        aresetn        <= 1'b0;
        cfg_wr_en      <= 1'b0;
        cfg_index      <= '0;
        cfg_wdata      <= '0;
        s_valid        <= 1'b0;
        s_request_size <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Default settings: empty, tiny, oversized and exact power-of-two requests
        send_request(16'd0);
        send_request(16'hFFFF);
        send_request(16'd1);
        send_request(16'd8);
        send_request(16'd9);
        send_request(16'd247);
        send_request(16'd248);
        send_request(16'd65527);
        drain();

        // Single-byte heap: zero total fits, one more byte exhausts, two is too large
        write_cfg(REG_MIN_ORDER, 8'd0);
        write_cfg(REG_MAX_ORDER, 8'd0);
        write_cfg(REG_HEADER_SIZE, 8'd0);
        send_request(16'd0);
        send_request(16'd1);
        send_request(16'd2);
        drain();

        // Minimum order above heap order: raised request finds no slot
        write_cfg(REG_MIN_ORDER, 8'd10);
        write_cfg(REG_MAX_ORDER, 8'd5);
        send_request(16'd0);
        drain();

        // Saturated orders, largest header, total beyond 16 bits
        write_cfg(REG_MIN_ORDER, 8'hFF);
        write_cfg(REG_MAX_ORDER, 8'hFF);
        write_cfg(REG_HEADER_SIZE, 8'hFF);
        send_request(16'hFFFF);
        send_request(16'd0);
        send_request(16'd0);
        drain();

        // Write to an unused index leaves the exhausted heap alone
        write_cfg(REG_UNUSED, 8'hA5);
        send_request(16'd0);
        drain();

        // Random phases; the fourth one holds the result side off
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            run_phase(phase == 3);
            phase++;
        end

        while (tracker.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/bba_pkg.sv
rtl/bba_front.sv
rtl/bba_queue.sv
rtl/bba_back.sv
rtl/buddy_block_allocator.sv
rtl/bba_checker.sv
bench/tb_buddy_block_allocator.sv
